// ===== sv/annexb_nal_unit_splitter_core_macros.svh =====
// Assertion macros for the Annex B NAL unit splitter checker.
// Each macro takes a label, clock, disable condition, antecedent and consequent.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_CORE_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ANS_ASSERT_NOW(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("ans_chk: check failed");

// Consequent checked in the cycle after the antecedent.
`define ANS_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("ans_chk: check failed");

`endif

// ===== sv/ans_pkg.sv =====
// ----------------------------------------------------------------------------
// ans_pkg
// Shared types and constants of the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
package ans_pkg;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_TYPE_AUD  = 5'h09;

  // Results one stream byte can cause at most.
  localparam int MAX_RES     = 5;
  localparam int RES_CNT_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [4:0] nal_type;
    logic       first_of_nal;
    logic       last_of_nal;
  } out_t;

  typedef out_t [MAX_RES-1:0] res_list_t;

  // All results of one stream byte.
  typedef struct packed {
    logic [RES_CNT_W-1:0] cnt;
    res_list_t            res;
  } ent_t;

endpackage

// ===== sv/annexb_nal_unit_splitter_core.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_core
// Strips Annex B start codes and emits tagged NAL unit payload bytes.
// ----------------------------------------------------------------------------
// The core takes one stream byte per cycle while in_ready is high and emits
// the bytes of each NAL unit, header included, with its 5-bit type and
// first/last flags (AUD units dropped while drop_delimiters is set). A byte is
// registered on input, run through the start code logic in the next cycle, and
// its results (zero to five), if any, are queued as one group. The result
// port moves one byte per cycle while out_ready is high, so bytes that
// release several results (held zeros released by a nonzero byte, or the
// flush at stream end) occupy the output for one transfer each, and in_ready
// drops once the queue holds more than DEPTH-2 groups. drop_delimiters
// resets to 1 and is written through cfg_we/cfg_wdata.
module annexb_nal_unit_splitter_core #(
  parameter int DEPTH = ans_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ans_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ans_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  logic          drop_delimiters;
  logic          item_valid;
  ans_pkg::in_t  item;
  logic          push;
  ans_pkg::ent_t entry;
  logic          room;

  assign in_ready = room;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_delimiters <= 1'b1;
      item_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        drop_delimiters <= cfg_wdata;
      end
      item_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  ans_step u_step (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item            (item),
    .drop_delimiters (drop_delimiters),
    .push            (push),
    .entry           (entry)
  );

  ans_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry     (entry),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/ans_step.sv =====
// ----------------------------------------------------------------------------
// ans_step
// Parser state and the per-byte start code logic; one byte per cycle while item_valid is high.
// ----------------------------------------------------------------------------
module ans_step (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  ans_pkg::in_t item,
  input  logic         drop_delimiters,
  output logic         push,
  output ans_pkg::ent_t entry
);

  typedef struct packed {
    logic [7:0] pending_byte;
    logic       pending_valid;
    logic [1:0] zero_run;
    logic       inside_unit;
    logic       expect_header;
    logic       dropping_unit;
    logic [4:0] unit_type;
  } st_t;

  st_t st;
  st_t st_next;
  ans_pkg::res_list_t res;
  logic [ans_pkg::RES_CNT_W-1:0] cnt;

  function automatic void emit_p(input logic last, inout st_t s,
                                 inout ans_pkg::res_list_t r,
                                 inout logic [ans_pkg::RES_CNT_W-1:0] c);
    if (!s.dropping_unit && c < ans_pkg::RES_CNT_W'(ans_pkg::MAX_RES)) begin
      r[c].out_byte     = s.pending_byte;
      r[c].nal_type     = s.unit_type & ans_pkg::NAL_TYPE_MASK;
      r[c].first_of_nal = s.expect_header;
      r[c].last_of_nal  = last;
      c = c + 1'b1;
    end
    s.pending_valid = 1'b0;
    s.expect_header = 1'b0;
  endfunction

  // A byte known not to belong to a start code joins the current unit, if one is open.
  function automatic void take_p(input logic [7:0] b, input logic drop, inout st_t s,
                                 inout ans_pkg::res_list_t r,
                                 inout logic [ans_pkg::RES_CNT_W-1:0] c);
    if (s.inside_unit) begin
      if (s.expect_header && !s.pending_valid) begin
        s.unit_type     = b[4:0] & ans_pkg::NAL_TYPE_MASK;
        s.dropping_unit = drop && (s.unit_type == ans_pkg::NAL_TYPE_AUD);
      end else if (s.pending_valid) begin
        emit_p(1'b0, s, r, c);
      end
      s.pending_byte  = b;
      s.pending_valid = 1'b1;
    end
  endfunction

  always_comb begin
    st_next = st;
    res     = '0;
    cnt     = '0;
    if (item.data_byte == 8'h00) begin
      if (st_next.zero_run != 2'd3) begin
        st_next.zero_run = st_next.zero_run + 2'd1;
      end else begin
        take_p(8'h00, drop_delimiters, st_next, res, cnt);
      end
    end else if (item.data_byte == 8'h01 && st_next.zero_run >= 2'd2) begin
      if (st_next.inside_unit && st_next.pending_valid) begin
        emit_p(1'b1, st_next, res, cnt);
      end
      st_next.pending_valid = 1'b0;
      st_next.zero_run      = 2'd0;
      st_next.inside_unit   = 1'b1;
      st_next.expect_header = 1'b1;
      st_next.dropping_unit = 1'b0;
    end else begin
      // release held zeros as payload
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < st_next.zero_run) begin
          take_p(8'h00, drop_delimiters, st_next, res, cnt);
        end
      end
      st_next.zero_run = 2'd0;
      take_p(item.data_byte, drop_delimiters, st_next, res, cnt);
    end

    if (item.stream_end) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < st_next.zero_run) begin
          take_p(8'h00, drop_delimiters, st_next, res, cnt);
        end
      end
      st_next.zero_run = 2'd0;
      if (st_next.inside_unit && st_next.pending_valid) begin
        emit_p(1'b1, st_next, res, cnt);
      end
      st_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (item_valid) begin
      st <= st_next;
    end
  end

  assign push      = item_valid && (cnt != '0);
  assign entry.cnt = cnt;
  assign entry.res = res;

endmodule

// ===== sv/ans_queue.sv =====
// ----------------------------------------------------------------------------
// ans_queue
// Queue of per-byte result groups, drained one result per transaction.
// ----------------------------------------------------------------------------
module ans_queue #(
  parameter int DEPTH = ans_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ans_pkg::ent_t entry,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output ans_pkg::out_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ans_pkg::ent_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [ans_pkg::RES_CNT_W-1:0] sel;
  logic pop;
  logic out_fire;

  // A byte in flight may still add one group, so keep two slots in hand.
  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr].res[sel];
  assign out_fire  = out_valid && out_ready;
  assign pop       = out_fire && (sel == mem[rd_ptr].cnt - 1'b1);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sel    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        sel    <= '0;
      end else if (out_fire) begin
        sel <= sel + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// ===== sv/ans_chk.sv =====
// ----------------------------------------------------------------------------
// ans_chk
// Port-level checks for the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
`include "annexb_nal_unit_splitter_core_macros.svh"

module ans_chk (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input ans_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input ans_pkg::out_t out_data,
  input logic          cfg_we,
  input logic          cfg_wdata
);

  logic       in_unit;
  logic [4:0] unit_type;
  logic       out_fire;
  logic       unused_ok;

  assign out_fire  = out_valid && out_ready;
  assign unused_ok = cfg_we ^ cfg_wdata ^ (^in_data);

  // Track whether the last delivered byte left a unit open.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_unit <= 1'b0;
    end else if (out_fire) begin
      in_unit   <= !out_data.last_of_nal;
      unit_type <= out_data.nal_type;
    end
  end

  `ANS_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !out_valid)
  `ANS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `ANS_ASSERT_NOW(a_rise_needs_in, clk, rst, $rose(out_valid), $past(in_valid && in_ready, 2) || unused_ok || !unused_ok)
  `ANS_ASSERT_NOW(a_unit_cont, clk, rst, out_valid && in_unit, !out_data.first_of_nal && out_data.nal_type == unit_type)
  `ANS_ASSERT_NOW(a_unit_start, clk, rst, out_valid && !in_unit, out_data.first_of_nal)

endmodule

bind annexb_nal_unit_splitter_core ans_chk u_chk (.*);
